@@ rtl/core/lzss_pkg.sv @@
// shared constants and controller/datapath interface types for the lzss window decompressor
package lzss_pkg;

    // history window geometry, fixed by the 11-bit distance field of a token
    localparam int WIN_AW    = 11;
    localparam int WIN_DEPTH = 2048;

    // match length field and copy buffer depth
    localparam int LEN_W   = 5;
    localparam int RUN_MAX = 32;
    localparam int RUN_CW  = LEN_W + 1;

    // data byte and output counter
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // flag mask value loaded with a new flag byte
    localparam logic [BYTE_W-1:0] FLAG_FIRST = 8'h80;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic read_en;
        logic write_en;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic awaiting;
        logic read_last;
        logic write_last;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/lzss_window_decompressor_top.sv @@
// top level of the lzss window decompressor: controller plus datapath
//
// Decompresses an lzss stream with a 2048-byte history and 16-bit tokens,
// one compressed byte per input beat. After reset the block runs a pass
// that zeroes all 2048 history bytes, with in_stall held high. A flag
// byte or a token low byte gives no output beat; a literal gives its
// output beat in the next cycle. A token high byte of length n (1..32)
// is accepted, then its n source bytes are read through the registered
// history port into the copy buffer, then written back to the history
// with one output beat each. Output stalls extend the write phase.
module lzss_window_decompressor_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lzss_pkg::BYTE_W-1:0]  in_byte,
    input  logic                         end_of_block,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lzss_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last_of_run,
    output logic [lzss_pkg::CNT_W-1:0]   total_out
);

    lzss_pkg::cmd_t cmd;
    lzss_pkg::sts_t sts;

    // sequencing
    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // window, decode state and output register
    lzss_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_byte      (in_byte),
        .end_of_block (end_of_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .total_out    (total_out)
    );

endmodule

@@ rtl/core/lzss_ram.sv @@
// generic simple dual-port ram with registered read
module lzss_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lzss_ctrl.sv @@
// sequencing state machine: clear pass, item accept, match read and match write phases
module lzss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output lzss_pkg::cmd_t cmd,
    input  lzss_pkg::sts_t sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   idle_free;

    // commands decoded from the current state
    assign idle_free    = (state_reg == ST_IDLE) && sts.out_free;
    assign in_stall     = !idle_free;
    assign cmd.clear_en = (state_reg == ST_CLEAR);
    assign cmd.accept   = idle_free && in_valid;
    assign cmd.read_en  = (state_reg == ST_READ);
    assign cmd.write_en = (state_reg == ST_WRITE) && sts.out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.accept && sts.awaiting)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.read_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (cmd.write_en && sts.write_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/lzss_dp.sv @@
// datapath: history window, copy buffer, decode state, output register and counter
module lzss_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lzss_pkg::cmd_t                   cmd,
    output lzss_pkg::sts_t                   sts,
    input  logic [lzss_pkg::BYTE_W-1:0]      in_byte,
    input  logic                             end_of_block,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lzss_pkg::BYTE_W-1:0]      out_byte,
    output logic                             last_of_run,
    output logic [lzss_pkg::CNT_W-1:0]       total_out
);

    typedef enum logic [1:0] {
        IK_TOKEN,
        IK_FLAG,
        IK_LOW,
        IK_LIT
    } item_kind_t;

    // decode and block state
    logic [lzss_pkg::WIN_AW-1:0] wp_reg, wp_next;
    logic [lzss_pkg::BYTE_W-1:0] flag_bits_reg, flag_bits_next;
    logic [lzss_pkg::BYTE_W-1:0] flag_mask_reg, flag_mask_next;
    logic [lzss_pkg::BYTE_W-1:0] token_low_reg, token_low_next;
    logic                        awaiting_reg, awaiting_next;
    logic [lzss_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        eob_reg, eob_next;

    // clear pass and match sequencing
    logic [lzss_pkg::WIN_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [lzss_pkg::RUN_CW-1:0] rd_step_reg, rd_step_next;
    logic [lzss_pkg::LEN_W-1:0]  wr_idx_reg, wr_idx_next;
    logic                        out_valid_reg, out_valid_next;

    // payload registers
    logic [lzss_pkg::LEN_W-1:0]  len_reg;
    logic [lzss_pkg::WIN_AW-1:0] src_reg;
    logic [lzss_pkg::BYTE_W-1:0] copy_reg [lzss_pkg::RUN_MAX];
    logic [lzss_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_last_reg;
    logic [lzss_pkg::CNT_W-1:0]  out_total_reg;

    // combinational helpers
    item_kind_t                  kind;
    logic                        lit_accept;
    logic                        tok_accept;
    logic                        out_load;
    logic [lzss_pkg::CNT_W-1:0]  cnt_inc;
    logic [lzss_pkg::WIN_AW-1:0] dist_m1;
    logic [lzss_pkg::LEN_W-1:0]  cap_idx;
    logic                        rd_issue;
    logic [lzss_pkg::BYTE_W-1:0] copy_out;
    logic                        hist_we;
    logic [lzss_pkg::WIN_AW-1:0] hist_waddr;
    logic [lzss_pkg::BYTE_W-1:0] hist_wdata;
    logic [lzss_pkg::WIN_AW-1:0] hist_raddr;
    logic [lzss_pkg::BYTE_W-1:0] hist_rdata;

    // classify the byte at the input
    always_comb
    begin
        if (awaiting_reg)
        begin
            kind = IK_TOKEN;
        end
        else if (flag_mask_reg == '0)
        begin
            kind = IK_FLAG;
        end
        else if ((flag_bits_reg & flag_mask_reg) != '0)
        begin
            kind = IK_LOW;
        end
        else
        begin
            kind = IK_LIT;
        end
    end

    assign lit_accept = cmd.accept && (kind == IK_LIT);
    assign tok_accept = cmd.accept && (kind == IK_TOKEN);
    assign out_load   = lit_accept || cmd.write_en;
    assign cnt_inc    = (count_reg == lzss_pkg::CNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;
    assign dist_m1    = {in_byte, token_low_reg[lzss_pkg::BYTE_W-1:lzss_pkg::LEN_W]};

    // match read sequencing: issue reads at steps 0..len, capture each at the next step
    assign rd_issue   = rd_step_reg <= {1'b0, len_reg};
    assign cap_idx    = rd_step_reg[lzss_pkg::LEN_W-1:0] - 1'b1;
    assign hist_raddr = src_reg + {{(lzss_pkg::WIN_AW-lzss_pkg::LEN_W){1'b0}},
                                   rd_step_reg[lzss_pkg::LEN_W-1:0]};
    assign copy_out   = copy_reg[wr_idx_reg];

    // history write port select
    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = wp_reg;
        hist_wdata = copy_out;
        if (cmd.clear_en)
        begin
            hist_we    = 1'b1;
            hist_waddr = clr_idx_reg;
            hist_wdata = '0;
        end
        else if (lit_accept)
        begin
            hist_we    = 1'b1;
            hist_wdata = in_byte;
        end
        else if (cmd.write_en)
        begin
            hist_we = 1'b1;
        end
    end

    lzss_ram #(
        .DATA_W (lzss_pkg::BYTE_W),
        .DEPTH  (lzss_pkg::WIN_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (cmd.read_en && rd_issue),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // status to the controller
    assign sts.clear_last = (clr_idx_reg == '1);
    assign sts.awaiting   = awaiting_reg;
    assign sts.read_last  = (rd_step_reg == {1'b0, len_reg} + 1'b1);
    assign sts.write_last = (wr_idx_reg == len_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // next state of control registers
    always_comb
    begin
        wp_next        = wp_reg;
        flag_bits_next = flag_bits_reg;
        flag_mask_next = flag_mask_reg;
        token_low_next = token_low_reg;
        awaiting_next  = awaiting_reg;
        count_next     = count_reg;
        eob_next       = eob_reg;
        clr_idx_next   = clr_idx_reg;
        rd_step_next   = rd_step_reg;
        wr_idx_next    = wr_idx_reg;

        if (cmd.clear_en)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            case (kind)
                IK_TOKEN:
                begin
                    awaiting_next  = 1'b0;
                    flag_mask_next = flag_mask_reg >> 1;
                    eob_next       = end_of_block;
                    rd_step_next   = '0;
                    wr_idx_next    = '0;
                end
                IK_FLAG:
                begin
                    flag_bits_next = in_byte;
                    flag_mask_next = lzss_pkg::FLAG_FIRST;
                end
                IK_LOW:
                begin
                    token_low_next = in_byte;
                    awaiting_next  = 1'b1;
                end
                IK_LIT:
                begin
                    wp_next        = wp_reg + 1'b1;
                    flag_mask_next = flag_mask_reg >> 1;
                    count_next     = cnt_inc;
                end
                default:
                begin
                    awaiting_next = 1'b0;
                end
            endcase
            // end of block on anything but a token high byte clears at once
            if (end_of_block && (kind != IK_TOKEN))
            begin
                wp_next        = '0;
                flag_bits_next = '0;
                flag_mask_next = '0;
                token_low_next = '0;
                awaiting_next  = 1'b0;
                count_next     = '0;
            end
        end

        if (cmd.read_en)
        begin
            rd_step_next = rd_step_reg + 1'b1;
        end

        if (cmd.write_en)
        begin
            wp_next     = wp_reg + 1'b1;
            count_next  = cnt_inc;
            wr_idx_next = wr_idx_reg + 1'b1;
            // end of block on a token clears after its last byte
            if (sts.write_last && eob_reg)
            begin
                wp_next        = '0;
                flag_bits_next = '0;
                flag_mask_next = '0;
                token_low_next = '0;
                awaiting_next  = 1'b0;
                count_next     = '0;
            end
        end
    end

    // output register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            flag_bits_reg <= '0;
            flag_mask_reg <= '0;
            token_low_reg <= '0;
            awaiting_reg  <= 1'b0;
            count_reg     <= '0;
            eob_reg       <= 1'b0;
            clr_idx_reg   <= '0;
            rd_step_reg   <= '0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            flag_bits_reg <= flag_bits_next;
            flag_mask_reg <= flag_mask_next;
            token_low_reg <= token_low_next;
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            eob_reg       <= eob_next;
            clr_idx_reg   <= clr_idx_next;
            rd_step_reg   <= rd_step_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // match geometry latched on the token high byte
    always_ff @(posedge clk)
    begin
        if (tok_accept)
        begin
            len_reg <= token_low_reg[lzss_pkg::LEN_W-1:0];
            src_reg <= wp_reg + ~dist_m1;
        end
    end

    // copy buffer fill from the history read port
    always_ff @(posedge clk)
    begin
        if (cmd.read_en && (rd_step_reg != '0))
        begin
            copy_reg[cap_idx] <= hist_rdata;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (lit_accept)
        begin
            out_byte_reg  <= in_byte;
            out_last_reg  <= 1'b1;
            out_total_reg <= cnt_inc;
        end
        else if (cmd.write_en)
        begin
            out_byte_reg  <= copy_out;
            out_last_reg  <= sts.write_last;
            out_total_reg <= cnt_inc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign total_out   = out_total_reg;

`ifndef SYNTHESIS
    // no output beat while the window is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> !out_valid_reg)
        else $error("output valid during window clear");

    // the read phase of a match never writes the history
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_en |-> !hist_we)
        else $error("history written during match read");

    // the final byte of a match is marked as last of run
    a_match_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_en && sts.write_last) |=> (out_valid_reg && out_last_reg))
        else $error("match end not flagged as last of run");
`endif

endmodule
